@@ rtl/lrs_pkg.sv @@
package lrs_pkg;

    localparam int unsigned WORD_W = 32;
    localparam int unsigned MUL_W  = WORD_W + 1;
    localparam int unsigned PROD_W = 2 * WORD_W;
    localparam int unsigned CNT_W  = $clog2(WORD_W);
    localparam int unsigned FAC_W  = 17;
    localparam int unsigned IDX_W  = 3;

    localparam logic [1:0] MODE_CONST  = 2'd0;
    localparam logic [1:0] MODE_NEWBOB = 2'd1;
    localparam logic [1:0] MODE_STEP   = 2'd2;

    localparam logic [IDX_W-1:0] REG_MODE       = 3'd0;
    localparam logic [IDX_W-1:0] REG_INIT_RATE  = 3'd1;
    localparam logic [IDX_W-1:0] REG_NB_FACTOR  = 3'd2;
    localparam logic [IDX_W-1:0] REG_STEP_INTVL = 3'd3;
    localparam logic [IDX_W-1:0] REG_STEP_FACT  = 3'd4;
    localparam logic [IDX_W-1:0] REG_COUNT_ERR  = 3'd5;

    localparam logic [WORD_W-1:0] RST_RATE       = 32'd16777216;
    localparam logic [FAC_W-1:0]  RST_NB_FACTOR  = 17'd32768;
    localparam logic [WORD_W-1:0] RST_STEP_INTVL = 32'd10000;
    localparam logic [FAC_W-1:0]  RST_STEP_FACT  = 17'd6554;

    localparam logic [PROD_W-1:0] SUM_MAX = {1'b0, {(PROD_W-1){1'b1}}};
    localparam logic [PROD_W-1:0] SUM_MIN = {1'b1, {(PROD_W-1){1'b0}}};

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_DECIDE,
        ST_REM,
        ST_STEP,
        ST_MUL_LHS,
        ST_MUL_RHS,
        ST_CMP,
        ST_MUL_RATE,
        ST_SAT_RATE,
        ST_MUL_OBJ,
        ST_ACC,
        ST_DONE
    } t_state;

    typedef struct packed {
        logic busy;
        logic done;
    } t_rem_status;

endpackage

@@ rtl/learning_rate_scheduler.sv @@
// Learning-rate scheduler: one batch report in, one learning rate out.
// Input stream s_axis_*: a batch report (epoch, observations, errors and
// mean objective) packed in tdata. Output stream m_axis_*: the rate after
// the update in tdata, and in tuser a flag set when this item scaled it.
// Config channel i_cfg_*: register index and data, always ready; write only
// while no item is in flight. Writing the initial rate reloads the rate.
// Items are handled one at a time by a sequencer around one shared 33x33
// multiplier and a bit-serial remainder unit. Steps after an item is accepted:
//   constant mode: the result is registered directly
//   newbob mode: objective product and accumulate; on an epoch boundary
//   with observations, two error-ratio products and a compare come first,
//   then scaling if the rate is reduced
//   step mode: step check, then scaling if due; the first step item after a
//   write of the interval register runs the remainder unit (one bit/cycle)
// The sequencer goes back to idle as the result is registered.
// s_axis_tready is high only in the idle state. If m_axis_tready is low the
// finished result waits in the output register; the next item may be taken
// meanwhile but stalls in its last state until the register frees.
// Synchronous active-low reset restores the state, configuration, schedule
// and output registers to their defaults, rate = 1.0, and clears the output valid.
module learning_rate_scheduler
    import lrs_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              s_axis_tvalid,
    output logic              s_axis_tready,
    // [31:0] epoch_number, [47:32] batch_observations,
    // [63:48] batch_errors, [95:64] batch_objective
    input  logic [95:0]       s_axis_tdata,
    output logic              m_axis_tvalid,
    input  logic              m_axis_tready,
    // [31:0] learning_rate
    output logic [WORD_W-1:0] m_axis_tdata,
    // [0] rate_reduced
    output logic              m_axis_tuser,
    input  logic              i_cfg_valid,
    output logic              o_cfg_ready,
    input  logic [IDX_W-1:0]  i_cfg_index,
    input  logic [WORD_W-1:0] i_cfg_data
);

    t_state r_state;
    t_state n_state;

    // configuration
    logic [1:0]        r_mode;
    logic [FAC_W-1:0]  r_nb_factor;
    logic [WORD_W-1:0] r_step_intvl;
    logic [FAC_W-1:0]  r_step_fact;
    logic              r_count_err;

    // scheduler state
    logic [WORD_W-1:0] r_rate;
    logic              r_first;
    logic [WORD_W-1:0] r_last_epoch;
    logic [WORD_W-1:0] r_ep_obs;
    logic [WORD_W-1:0] r_ep_err;
    logic [PROD_W-1:0] r_ep_sum;
    logic [WORD_W-1:0] r_prev_err;
    logic [WORD_W-1:0] r_prev_obs;
    logic [PROD_W-1:0] r_prev_sum;
    logic [WORD_W-1:0] r_batch_cnt;
    logic [WORD_W-1:0] r_mod;
    logic              r_mod_valid;

    // item in flight
    logic [WORD_W-1:0] r_epoch;
    logic [15:0]       r_obs;
    logic [15:0]       r_errs;
    logic [WORD_W-1:0] r_obj;
    logic              r_reduced;
    logic [PROD_W-1:0] r_lhs;

    // output register
    logic              r_out_valid;
    logic [WORD_W-1:0] r_out_rate;
    logic              r_out_red;

    logic signed [MUL_W-1:0] w_mul_a;
    logic signed [MUL_W-1:0] w_mul_b;
    logic [PROD_W-1:0]       w_prod;
    logic                    w_rem_start;
    t_rem_status             w_rem_st;
    logic [WORD_W-1:0]       w_rem;

    logic                    w_in_acc;
    logic                    w_out_free;
    logic [WORD_W-1:0]       w_eff_last;
    logic                    w_new_epoch;
    logic [WORD_W-1:0]       w_cnt_inc;
    logic [WORD_W:0]         w_mod_inc;
    logic [WORD_W-1:0]       w_new_mod;
    logic                    w_step_red;
    logic                    w_nb_red;
    logic [FAC_W-1:0]        w_factor;
    logic [PROD_W-17:0]      w_scaled;
    logic [WORD_W:0]         w_obs_sum;
    logic [WORD_W:0]         w_err_sum;
    logic [PROD_W-1:0]       w_obj_sum;
    logic                    w_obj_ovf;

    assign w_in_acc      = s_axis_tvalid && s_axis_tready;
    assign w_out_free    = !r_out_valid || m_axis_tready;
    assign s_axis_tready = (r_state == ST_IDLE);
    assign o_cfg_ready   = 1'b1;

    assign w_eff_last  = r_first ? r_epoch : r_last_epoch;
    assign w_new_epoch = r_epoch > w_eff_last;

    assign w_cnt_inc  = r_batch_cnt + 1'b1;
    assign w_mod_inc  = {1'b0, r_mod} + 1'b1;
    assign w_new_mod  = ((w_cnt_inc == '0) || (w_mod_inc == {1'b0, r_step_intvl}))
                        ? '0 : w_mod_inc[WORD_W-1:0];
    assign w_step_red = (r_step_intvl != '0) && (w_new_mod == '0);

    assign w_nb_red = (r_lhs > w_prod) ||
                      ((r_lhs == w_prod) && ($signed(r_ep_sum) >= $signed(r_prev_sum)));

    assign w_factor = (r_mode == MODE_STEP) ? r_step_fact : r_nb_factor;
    assign w_scaled = w_prod[PROD_W-1:16];

    assign w_obs_sum = {1'b0, r_ep_obs} + {17'd0, r_obs};
    assign w_err_sum = {1'b0, r_ep_err} + {17'd0, r_errs};
    assign w_obj_sum = r_ep_sum + w_prod;
    assign w_obj_ovf = (r_ep_sum[PROD_W-1] == w_prod[PROD_W-1]) &&
                       (w_obj_sum[PROD_W-1] != r_ep_sum[PROD_W-1]);

    assign w_rem_start = (r_state == ST_DECIDE) && (r_mode == MODE_STEP) &&
                         (r_step_intvl != '0) && !r_mod_valid;

    always_comb begin
        unique case (r_state)
            ST_MUL_LHS: begin
                w_mul_a = {1'b0, r_ep_err};
                w_mul_b = {1'b0, r_prev_obs};
            end
            ST_MUL_RHS: begin
                w_mul_a = {1'b0, r_prev_err};
                w_mul_b = {1'b0, r_ep_obs};
            end
            ST_MUL_RATE: begin
                w_mul_a = {1'b0, r_rate};
                w_mul_b = {{(MUL_W-FAC_W){1'b0}}, w_factor};
            end
            ST_MUL_OBJ: begin
                w_mul_a = {r_obj[WORD_W-1], r_obj};
                w_mul_b = {{(MUL_W-16){1'b0}}, r_obs};
            end
            default: begin
                w_mul_a = '0;
                w_mul_b = '0;
            end
        endcase
    end

    lrs_mul u_mul (
        .i_clk  (i_clk),
        .i_a    (w_mul_a),
        .i_b    (w_mul_b),
        .o_prod (w_prod)
    );

    lrs_rem u_rem (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (w_rem_start),
        .i_dividend (r_batch_cnt),
        .i_divisor  (r_step_intvl),
        .o_status   (w_rem_st),
        .o_rem      (w_rem)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ST_IDLE: begin
                if (w_in_acc) begin
                    n_state = ST_DECIDE;
                end
            end
            ST_DECIDE: begin
                if (r_mode == MODE_NEWBOB) begin
                    if (w_new_epoch && (r_ep_obs != '0)) begin
                        n_state = ST_MUL_LHS;
                    end else begin
                        n_state = ST_MUL_OBJ;
                    end
                end else if (r_mode == MODE_STEP) begin
                    n_state = w_rem_start ? ST_REM : ST_STEP;
                end else begin
                    n_state = ST_DONE;
                end
            end
            ST_REM: begin
                if (w_rem_st.done) begin
                    n_state = ST_STEP;
                end
            end
            ST_STEP:     n_state = w_step_red ? ST_MUL_RATE : ST_DONE;
            ST_MUL_LHS:  n_state = ST_MUL_RHS;
            ST_MUL_RHS:  n_state = ST_CMP;
            ST_CMP:      n_state = w_nb_red ? ST_MUL_RATE : ST_MUL_OBJ;
            ST_MUL_RATE: n_state = ST_SAT_RATE;
            ST_SAT_RATE: n_state = (r_mode == MODE_NEWBOB) ? ST_MUL_OBJ : ST_DONE;
            ST_MUL_OBJ:  n_state = ST_ACC;
            ST_ACC:      n_state = ST_DONE;
            ST_DONE: begin
                if (w_out_free) begin
                    n_state = ST_IDLE;
                end
            end
            default:     n_state = ST_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (w_in_acc) begin
            r_epoch <= s_axis_tdata[31:0];
            r_obs   <= s_axis_tdata[47:32];
            r_errs  <= s_axis_tdata[63:48];
            r_obj   <= s_axis_tdata[95:64];
        end
        if (r_state == ST_MUL_RHS) begin
            r_lhs <= w_prod;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode       <= MODE_CONST;
            r_nb_factor  <= RST_NB_FACTOR;
            r_step_intvl <= RST_STEP_INTVL;
            r_step_fact  <= RST_STEP_FACT;
            r_count_err  <= 1'b1;
            r_rate       <= RST_RATE;
            r_first      <= 1'b1;
            r_last_epoch <= '0;
            r_ep_obs     <= '0;
            r_ep_err     <= '0;
            r_ep_sum     <= '0;
            r_prev_err   <= WORD_W'(1);
            r_prev_obs   <= WORD_W'(1);
            r_prev_sum   <= SUM_MAX;
            r_batch_cnt  <= '0;
            r_mod        <= '0;
            r_mod_valid  <= 1'b1;
            r_reduced    <= 1'b0;
            r_out_valid  <= 1'b0;
            r_out_rate   <= '0;
            r_out_red    <= 1'b0;
        end else begin
            if (i_cfg_valid) begin
                unique case (i_cfg_index)
                    REG_MODE:       r_mode <= i_cfg_data[1:0];
                    REG_INIT_RATE:  r_rate <= i_cfg_data;
                    REG_NB_FACTOR:  r_nb_factor <= i_cfg_data[FAC_W-1:0];
                    REG_STEP_INTVL: begin
                        r_step_intvl <= i_cfg_data;
                        r_mod_valid  <= 1'b0;
                    end
                    REG_STEP_FACT:  r_step_fact <= i_cfg_data[FAC_W-1:0];
                    REG_COUNT_ERR:  r_count_err <= i_cfg_data[0];
                    default: ;
                endcase
            end

            if ((r_state == ST_DONE) && w_out_free) begin
                r_out_valid <= 1'b1;
            end else if (m_axis_tvalid && m_axis_tready) begin
                r_out_valid <= 1'b0;
            end

            unique case (r_state)
                ST_IDLE: begin
                    r_reduced <= 1'b0;
                end
                ST_DECIDE: begin
                    if (r_mode == MODE_NEWBOB) begin
                        r_first      <= 1'b0;
                        r_last_epoch <= w_new_epoch ? r_epoch : w_eff_last;
                        if (w_new_epoch && (r_ep_obs == '0)) begin
                            r_ep_obs <= '0;
                            r_ep_err <= '0;
                            r_ep_sum <= '0;
                        end
                    end
                end
                ST_REM: begin
                    if (w_rem_st.done) begin
                        r_mod       <= w_rem;
                        r_mod_valid <= 1'b1;
                    end
                end
                ST_STEP: begin
                    r_batch_cnt <= w_cnt_inc;
                    r_mod       <= w_new_mod;
                    if (r_step_intvl == '0) begin
                        r_mod_valid <= 1'b0;
                    end
                    r_reduced <= w_step_red;
                end
                ST_CMP: begin
                    r_reduced  <= w_nb_red;
                    r_prev_err <= r_ep_err;
                    r_prev_obs <= r_ep_obs;
                    r_prev_sum <= r_ep_sum;
                    r_ep_obs   <= '0;
                    r_ep_err   <= '0;
                    r_ep_sum   <= '0;
                end
                ST_SAT_RATE: begin
                    r_rate <= (w_scaled[PROD_W-17:WORD_W] != '0) ? '1
                                                                  : w_scaled[WORD_W-1:0];
                end
                ST_ACC: begin
                    r_ep_obs <= w_obs_sum[WORD_W] ? '1 : w_obs_sum[WORD_W-1:0];
                    if (r_count_err) begin
                        r_ep_err <= w_err_sum[WORD_W] ? '1 : w_err_sum[WORD_W-1:0];
                    end
                    if (w_obj_ovf) begin
                        r_ep_sum <= r_ep_sum[PROD_W-1] ? SUM_MIN : SUM_MAX;
                    end else begin
                        r_ep_sum <= w_obj_sum;
                    end
                end
                ST_DONE: begin
                    if (w_out_free) begin
                        r_out_rate  <= r_rate;
                        r_out_red   <= r_reduced;
                    end
                end
                default: ;
            endcase
        end
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = r_out_rate;
    assign m_axis_tuser  = r_out_red;

    a_busy_not_ready: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_in_acc |=> (r_state == ST_DECIDE) && !s_axis_tready)
        else $error("item accepted while sequencer busy");

    a_rem_done_in_wait: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_rem_st.done |-> (r_state == ST_REM))
        else $error("remainder finished outside its wait state");

    a_reduce_mode: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_MUL_RATE) |-> (r_mode == MODE_NEWBOB || r_mode == MODE_STEP))
        else $error("rate scaled in constant mode");

    a_out_load: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_DONE && w_out_free) |=> m_axis_tvalid && (m_axis_tdata == r_rate))
        else $error("result not presented after completion");

    a_stall_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_DONE && !w_out_free) |=> (r_state == ST_DONE))
        else $error("result dropped under output stall");

endmodule

@@ rtl/lrs_mul.sv @@
module lrs_mul
    import lrs_pkg::*;
(
    input  logic                     i_clk,
    input  logic signed [MUL_W-1:0]  i_a,
    input  logic signed [MUL_W-1:0]  i_b,
    output logic        [PROD_W-1:0] o_prod
);

    logic signed [2*MUL_W-1:0] w_full;
    logic        [PROD_W-1:0]  r_prod;

    assign w_full = i_a * i_b;

    always_ff @(posedge i_clk) begin
        r_prod <= w_full[PROD_W-1:0];
    end

    assign o_prod = r_prod;

endmodule

@@ rtl/lrs_rem.sv @@
module lrs_rem
    import lrs_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_start,
    input  logic [WORD_W-1:0] i_dividend,
    input  logic [WORD_W-1:0] i_divisor,
    output t_rem_status       o_status,
    output logic [WORD_W-1:0] o_rem
);

    logic              r_busy;
    logic              r_done;
    logic [CNT_W-1:0]  r_cnt;
    logic [WORD_W-1:0] r_dvd;
    logic [WORD_W-1:0] r_div;
    logic [WORD_W-1:0] r_rem;
    logic [WORD_W:0]   w_trial;
    logic [WORD_W:0]   w_diff;

    assign w_trial = {r_rem, r_dvd[WORD_W-1]};
    assign w_diff  = w_trial - {1'b0, r_div};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= CNT_W'(WORD_W - 1);
            end else if (r_busy) begin
                r_cnt <= r_cnt - 1'b1;
                if (r_cnt == '0) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_rem <= '0;
            r_dvd <= i_dividend;
            r_div <= i_divisor;
        end else if (r_busy) begin
            r_dvd <= {r_dvd[WORD_W-2:0], 1'b0};
            if (w_diff[WORD_W] == 1'b0) begin
                r_rem <= w_diff[WORD_W-1:0];
            end else begin
                r_rem <= w_trial[WORD_W-1:0];
            end
        end
    end

    assign o_status = '{busy: r_busy, done: r_done};
    assign o_rem    = r_rem;

endmodule

@@ test/learning_rate_scheduler_test.sv @@
`timescale 1ns / 100ps

module learning_rate_scheduler_test;
    import lrs_pkg::*;

    localparam logic [IDX_W-1:0] REG_SPARE  = 3'd7;
    localparam logic [1:0]       MODE_SPARE = 2'd3;

    localparam longint OBJ_SUM_MAX = 64'sh7FFF_FFFF_FFFF_FFFF;
    localparam longint OBJ_SUM_MIN = -OBJ_SUM_MAX - 64'sd1;

    localparam int unsigned SETTLE_CYCLES = 45;
    localparam int unsigned QUIET_LIMIT   = 2000;
    localparam int unsigned LONG_STALL    = 300;
    localparam int unsigned SHOWN_ERRORS  = 10;

    typedef struct packed {
        logic [WORD_W-1:0] rate;
        logic              reduced;
    } t_rate_out;

    logic              i_clk         = 1'b0;
    logic              i_rst_n       = 1'b0;
    logic              s_axis_tvalid = 1'b0;
    logic              s_axis_tready;
    logic [95:0]       s_axis_tdata  = '0;
    logic              m_axis_tvalid;
    logic              m_axis_tready = 1'b0;
    logic [WORD_W-1:0] m_axis_tdata;
    logic              m_axis_tuser;
    logic              i_cfg_valid   = 1'b0;
    logic              o_cfg_ready;
    logic [IDX_W-1:0]  i_cfg_index   = '0;
    logic [WORD_W-1:0] i_cfg_data    = '0;

    // register copy
    logic [1:0]        cfg_mode       = MODE_CONST;
    logic [FAC_W-1:0]  cfg_nb_factor  = RST_NB_FACTOR;
    logic [WORD_W-1:0] cfg_step_intvl = RST_STEP_INTVL;
    logic [FAC_W-1:0]  cfg_step_fact  = RST_STEP_FACT;
    logic              cfg_count_err  = 1'b1;

    // schedule state
    logic [WORD_W-1:0] rate_now      = RST_RATE;
    logic              nb_first      = 1'b1;
    logic [WORD_W-1:0] nb_last_epoch = '0;
    logic [WORD_W-1:0] ep_obs        = '0;
    logic [WORD_W-1:0] ep_err        = '0;
    longint            ep_obj_sum    = 0;
    logic [WORD_W-1:0] prev_err      = 32'd1;
    logic [WORD_W-1:0] prev_obs      = 32'd1;
    longint            prev_obj_sum  = OBJ_SUM_MAX;
    logic [WORD_W-1:0] step_count    = '0;

    t_rate_out   pending_rates[$];
    int unsigned reports_sent   = 0;
    int unsigned rates_checked  = 0;
    int unsigned reductions     = 0;
    int unsigned mismatch_count = 0;
    int unsigned quiet_cycles   = 0;
    int unsigned idle_odds      = 6;
    int unsigned stall_cycles   = 0;

    learning_rate_scheduler u_top (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .i_cfg_valid   (i_cfg_valid),
        .o_cfg_ready   (o_cfg_ready),
        .i_cfg_index   (i_cfg_index),
        .i_cfg_data    (i_cfg_data)
    );

    always #5 i_clk = ~i_clk;

    function automatic logic [WORD_W-1:0] scaled_rate(logic [WORD_W-1:0] rate,
                                                      logic [FAC_W-1:0] factor);
        logic [63:0] p;
        p = (64'(rate) * 64'(factor)) >> 16;
        return (p > 64'hFFFF_FFFF) ? 32'hFFFF_FFFF : p[31:0];
    endfunction

    function automatic logic [WORD_W-1:0] sat_add_u32(logic [WORD_W-1:0] a,
                                                      logic [WORD_W-1:0] b);
        logic [WORD_W:0] s;
        s = {1'b0, a} + {1'b0, b};
        return s[WORD_W] ? 32'hFFFF_FFFF : s[WORD_W-1:0];
    endfunction

    function automatic longint sat_add_s64(longint a, longint b);
        if (b > 0 && a > OBJ_SUM_MAX - b) return OBJ_SUM_MAX;
        if (b < 0 && a < OBJ_SUM_MIN - b) return OBJ_SUM_MIN;
        return a + b;
    endfunction

    function automatic logic newbob_update(logic [31:0] epoch, logic [15:0] obs,
                                           logic [15:0] errs, logic signed [31:0] obj);
        logic [63:0] lhs;
        logic [63:0] rhs;
        logic        hit;
        hit = 1'b0;
        if (nb_first) begin
            nb_first      = 1'b0;
            nb_last_epoch = epoch;
        end
        if (epoch > nb_last_epoch) begin
            nb_last_epoch = epoch;
            if (ep_obs != 0) begin
                lhs = 64'(ep_err) * 64'(prev_obs);
                rhs = 64'(prev_err) * 64'(ep_obs);
                if (lhs > rhs || (lhs == rhs && ep_obj_sum >= prev_obj_sum)) begin
                    rate_now = scaled_rate(rate_now, cfg_nb_factor);
                    hit      = 1'b1;
                end
                prev_err     = ep_err;
                prev_obs     = ep_obs;
                prev_obj_sum = ep_obj_sum;
            end
            ep_obs     = '0;
            ep_err     = '0;
            ep_obj_sum = 0;
        end
        ep_obs = sat_add_u32(ep_obs, 32'(obs));
        if (cfg_count_err)
            ep_err = sat_add_u32(ep_err, 32'(errs));
        ep_obj_sum = sat_add_s64(ep_obj_sum, longint'(obj) * longint'({16'd0, obs}));
        return hit;
    endfunction

    function automatic t_rate_out predict_rate(logic [31:0] epoch, logic [15:0] obs,
                                               logic [15:0] errs, logic [31:0] obj);
        t_rate_out res;
        res.reduced = 1'b0;
        if (cfg_mode == MODE_NEWBOB) begin
            res.reduced = newbob_update(epoch, obs, errs, obj);
        end else if (cfg_mode == MODE_STEP) begin
            step_count = step_count + 32'd1;
            if (cfg_step_intvl != 0 && step_count % cfg_step_intvl == 0) begin
                rate_now    = scaled_rate(rate_now, cfg_step_fact);
                res.reduced = 1'b1;
            end
        end
        res.rate = rate_now;
        return res;
    endfunction

    function automatic void apply_register(logic [IDX_W-1:0] idx, logic [31:0] value);
        case (idx)
            REG_MODE:       cfg_mode = value[1:0];
            REG_INIT_RATE:  rate_now = value;
            REG_NB_FACTOR:  cfg_nb_factor  = value[FAC_W-1:0];
            REG_STEP_INTVL: cfg_step_intvl = value;
            REG_STEP_FACT:  cfg_step_fact  = value[FAC_W-1:0];
            REG_COUNT_ERR:  cfg_count_err  = value[0];
            default: ;
        endcase
    endfunction

    task automatic flag_mismatch(input string msg);
        mismatch_count++;
        if (mismatch_count <= SHOWN_ERRORS)
            $display("%0t: %s", $realtime, msg);
    endtask

    // drop valid, wait for every outstanding rate, then let the block settle
    task automatic drain_results();
        s_axis_tvalid <= 1'b0;
        while (pending_rates.size() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic write_register(input logic [IDX_W-1:0] idx, input logic [31:0] value);
        drain_results();
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= value;
        do @(posedge i_clk); while (!o_cfg_ready);
        apply_register(idx, value);
        i_cfg_valid <= 1'b0;
    endtask

    task automatic send_report(input logic [31:0] epoch, input logic [15:0] obs,
                               input logic [15:0] errs, input logic [31:0] obj);
        s_axis_tdata  <= {obj, errs, obs, epoch};
        s_axis_tvalid <= 1'b1;
        do @(posedge i_clk); while (!s_axis_tready);
        pending_rates.push_back(predict_rate(epoch, obs, errs, obj));
        reports_sent++;
        if (idle_odds != 0 && $urandom_range(1, idle_odds) == 1) begin
            s_axis_tvalid <= 1'b0;
            repeat ($urandom_range(1, 10)) @(posedge i_clk);
        end
    endtask

    task automatic send_noise();
        send_report($urandom, 16'($urandom), 16'($urandom), $urandom);
    endtask

    // receiver: random stall bursts, plus a long hold on request
    initial begin
        forever begin
            @(posedge i_clk);
            if (stall_cycles != 0) begin
                m_axis_tready <= 1'b0;
                repeat (stall_cycles) @(posedge i_clk);
                stall_cycles = 0;
                m_axis_tready <= 1'b1;
            end else if (idle_odds != 0 && $urandom_range(1, idle_odds) == 1) begin
                m_axis_tready <= 1'b0;
                repeat ($urandom_range(1, 10)) @(posedge i_clk);
                m_axis_tready <= 1'b1;
            end else begin
                m_axis_tready <= 1'b1;
            end
        end
    end

    always @(posedge i_clk) begin
        t_rate_out want;
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            if (pending_rates.size() == 0) begin
                flag_mismatch($sformatf("unexpected rate %h flag %b",
                                        m_axis_tdata, m_axis_tuser));
            end else begin
                want = pending_rates.pop_front();
                rates_checked++;
                if (m_axis_tuser) reductions++;
                if (m_axis_tdata !== want.rate)
                    flag_mismatch($sformatf("rate exp %h got %h", want.rate, m_axis_tdata));
                if (m_axis_tuser !== want.reduced)
                    flag_mismatch($sformatf("reduced flag exp %b got %b",
                                            want.reduced, m_axis_tuser));
            end
        end
    end

    always @(posedge i_clk) begin
        if (!i_rst_n || (s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)
                || (i_cfg_valid && o_cfg_ready)) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles >= QUIET_LIMIT) begin
            $display("no progress for %0d cycles", QUIET_LIMIT);
            $display("SCOREBOARD MISMATCH");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    task automatic test_constant_modes();
        send_report(32'd0, 16'd0, 16'd0, 32'd0);
        send_report(32'hFFFF_FFFF, 16'hFFFF, 16'hFFFF, 32'h7FFF_FFFF);
        send_report(32'h8000_0000, 16'h8000, 16'h0001, 32'h8000_0000);
        write_register(REG_SPARE, 32'hFFFF_FFFF);
        write_register(REG_INIT_RATE, 32'd0);
        send_report(32'd7, 16'd100, 16'd5, 32'hFFFF_0000);
        write_register(REG_MODE, 32'(MODE_SPARE));
        write_register(REG_INIT_RATE, 32'hFFFF_FFFF);
        send_report(32'd1, 16'hFFFF, 16'hFFFF, 32'hFFFF_FFFF);
        send_report(32'd2, 16'd0, 16'd0, 32'd0);
    endtask

    task automatic test_step_directed();
        write_register(REG_MODE, 32'(MODE_STEP));
        write_register(REG_STEP_INTVL, 32'd3);
        write_register(REG_STEP_FACT, 32'd32768);
        write_register(REG_INIT_RATE, 32'hFFFF_FFFF);
        repeat (4) send_report(32'd0, 16'd1, 16'd0, 32'd0);
        // factor above one saturates the rate
        write_register(REG_STEP_FACT, 32'h1_FFFF);
        write_register(REG_STEP_INTVL, 32'd1);
        write_register(REG_INIT_RATE, 32'h8000_0000);
        repeat (2) send_report(32'd0, 16'd1, 16'd0, 32'd0);
        // interval zero never reduces
        write_register(REG_STEP_INTVL, 32'd0);
        repeat (2) send_report(32'd0, 16'd1, 16'd0, 32'd0);
        write_register(REG_STEP_INTVL, 32'd1);
        write_register(REG_STEP_FACT, 32'd0);
        send_report(32'd0, 16'd1, 16'd0, 32'd0);
    endtask

    task automatic test_newbob_directed();
        write_register(REG_MODE, 32'(MODE_NEWBOB));
        write_register(REG_INIT_RATE, 32'(RST_RATE));
        write_register(REG_NB_FACTOR, 32'd32768);
        write_register(REG_COUNT_ERR, 32'd1);
        send_report(32'd10, 16'd100, 16'd10, 32'h0001_0000);
        send_report(32'd10, 16'd100, 16'd30, 32'h0001_0000);
        send_report(32'd9, 16'd50, 16'd0, 32'h0001_0000);     // stale epoch
        send_report(32'd11, 16'd100, 16'd10, 32'h0001_0000);
        send_report(32'd12, 16'd100, 16'd50, 32'h0001_0000);
        send_report(32'd13, 16'd0, 16'd9, 32'h0001_0000);     // empty epoch
        send_report(32'd14, 16'd40, 16'd20, 32'd0);
        send_report(32'd15, 16'd80, 16'd40, 32'd0);           // equal ratio
        send_report(32'd16, 16'd80, 16'd40, 32'hFFFF_0000);   // equal, sum not lower
        write_register(REG_COUNT_ERR, 32'd0);
        write_register(REG_NB_FACTOR, 32'h1_FFFF);
        write_register(REG_INIT_RATE, 32'hF000_0000);
        send_report(32'd17, 16'hFFFF, 16'hFFFF, 32'h8000_0000);
        send_report(32'd18, 16'hFFFF, 16'hFFFF, 32'h7FFF_FFFF);
        send_report(32'd19, 16'd1, 16'd1, 32'd0);
    endtask

    task automatic test_newbob_random();
        logic [31:0] epoch;
        logic [31:0] obj;
        logic [15:0] obs;
        logic [15:0] errs;
        int unsigned sent;
        int unsigned batches;
        bit          ties;
        bit          empty_epoch;
        bit          paused;
        paused = 1'b0;
        write_register(REG_MODE, 32'(MODE_NEWBOB));
        for (int phase = 0; phase < 4; phase++) begin
            ties      = phase[0];
            idle_odds = (phase == 2) ? 0 : 6;
            case (phase)
                0:       write_register(REG_NB_FACTOR, 32'd32768);
                1:       write_register(REG_NB_FACTOR, $urandom_range(1, 65536));
                2:       write_register(REG_NB_FACTOR, $urandom_range(65537, 131071));
                default: write_register(REG_NB_FACTOR, $urandom_range(40000, 65535));
            endcase
            write_register(REG_COUNT_ERR, 32'(phase != 3));
            write_register(REG_INIT_RATE, (phase == 1) ? 32'hFFFF_FFFF : $urandom);
            epoch = nb_last_epoch + 32'd1;
            sent  = 0;
            while (sent < 125) begin
                batches     = ties ? $urandom_range(1, 2) : $urandom_range(1, 5);
                empty_epoch = ($urandom_range(0, 11) == 0);
                for (int b = 0; b < batches; b++) begin
                    if (ties) begin
                        // small ratios so that equal error rates come up often
                        obs  = 16'd8 << $urandom_range(0, 1);
                        errs = 16'(2 * $urandom_range(0, 2));
                        obj  = 32'($signed($urandom_range(0, 2)) - 1) << 16;
                    end else begin
                        case ($urandom_range(0, 15))
                            0:       obs = 16'd0;
                            1:       obs = 16'hFFFF;
                            default: obs = 16'($urandom_range(1, 2000));
                        endcase
                        errs = ($urandom_range(0, 15) == 0) ? 16'($urandom)
                                                            : 16'($urandom_range(0, obs));
                        obj  = ($urandom_range(0, 3) == 0)
                             ? $urandom : 32'($signed($urandom_range(0, 262144)) - 131072);
                    end
                    if (empty_epoch) obs = 16'd0;
                    if ($urandom_range(0, 19) == 0)
                        send_report($urandom_range(0, epoch), obs, errs, obj);
                    else
                        send_report(epoch, obs, errs, obj);
                    sent++;
                end
                epoch = epoch + $urandom_range(1, 3);
                if (phase == 0 && !paused && sent >= 60) begin
                    drain_results();
                    paused = 1'b1;
                end
            end
        end
        idle_odds = 6;
    endtask

    task automatic test_output_backpressure();
        write_register(REG_MODE, 32'(MODE_STEP));
        write_register(REG_STEP_INTVL, 32'd2);
        write_register(REG_STEP_FACT, 32'd50000);
        write_register(REG_INIT_RATE, $urandom);
        idle_odds    = 0;
        stall_cycles = LONG_STALL;
        repeat (12) send_noise();
        drain_results();
        idle_odds = 6;
    endtask

    task automatic test_step_random();
        write_register(REG_MODE, 32'(MODE_STEP));
        for (int phase = 0; phase < 5; phase++) begin
            idle_odds = (phase == 1) ? 0 : 5;
            case (phase)
                3:       write_register(REG_STEP_INTVL, $urandom);
                4:       write_register(REG_STEP_INTVL, 32'd1);
                default: write_register(REG_STEP_INTVL, $urandom_range(1, 8));
            endcase
            if (phase == 2)
                write_register(REG_STEP_FACT, 65536 + $urandom_range(1, 65535));
            else
                write_register(REG_STEP_FACT, $urandom_range(0, 65536));
            write_register(REG_INIT_RATE, $urandom);
            repeat (50) send_noise();
        end
        idle_odds = 6;
    endtask

    task automatic test_constant_random();
        write_register(REG_MODE, 32'(MODE_CONST));
        write_register(REG_INIT_RATE, $urandom);
        repeat (25) send_noise();
        write_register(REG_MODE, 32'(MODE_SPARE));
        repeat (25) send_noise();
    endtask

    // no idling from here on; modes switch with their state kept
    task automatic test_mode_switch_tail();
        logic [31:0] epoch;
        idle_odds = 0;
        write_register(REG_MODE, 32'(MODE_STEP));
        write_register(REG_STEP_INTVL, 32'd5);
        write_register(REG_STEP_FACT, 32'd60000);
        write_register(REG_INIT_RATE, $urandom);
        repeat (60) send_noise();
        write_register(REG_MODE, 32'(MODE_NEWBOB));
        write_register(REG_COUNT_ERR, 32'd1);
        write_register(REG_NB_FACTOR, 32'd49152);
        epoch = nb_last_epoch + 32'd1;
        for (int i = 0; i < 60; i++) begin
            send_report(epoch, 16'($urandom_range(0, 64)), 16'($urandom_range(0, 64)),
                        32'($signed($urandom_range(0, 4)) - 2) << 16);
            if (i[0]) epoch = epoch + 32'd1;
        end
    endtask

    task automatic test_epoch_limit();
        write_register(REG_INIT_RATE, 32'(RST_RATE));
        send_report(32'hFFFF_FFFE, 16'd5, 16'd5, 32'h0001_0000);
        send_report(32'hFFFF_FFFF, 16'd5, 16'd5, 32'h0001_0000);
        send_report(32'hFFFF_FFFF, 16'd5, 16'd0, 32'd0);
        send_report(32'd0, 16'd5, 16'd5, 32'd0);
    endtask

    initial begin
        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;
        test_constant_modes();
        test_step_directed();
        test_newbob_directed();
        test_newbob_random();
        test_output_backpressure();
        test_step_random();
        test_constant_random();
        test_mode_switch_tail();
        test_epoch_limit();
        drain_results();
        $display("Ran %0d batch reports through constant, step and newbob schedules,",
                 reports_sent);
        $display("with back-pressure and mode changes: %0d rates checked, %0d reductions.",
                 rates_checked, reductions);
        if (mismatch_count == 0 && pending_rates.size() == 0) begin
            $display("SCOREBOARD CLEAN");
        end else begin
            $display("%0d mismatches, %0d rates outstanding",
                     mismatch_count, pending_rates.size());
            $display("SCOREBOARD MISMATCH");
        end
        $finish;
    end

endmodule

@@ learning_rate_scheduler.f @@
rtl/lrs_pkg.sv
rtl/lrs_mul.sv
rtl/lrs_rem.sv
rtl/learning_rate_scheduler.sv
test/learning_rate_scheduler_test.sv
